FILE: rtl/core/mdm_pkg.sv
// Shared types, mode codes and widths for the multiply/divide/modulo unit.
package mdm_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MODE_WIDTH = 3;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [MODE_WIDTH-1:0] t_mode;

    // Operation codes carried in the mode field.
    localparam t_mode MODE_MUL  = 3'd0;
    localparam t_mode MODE_UDIV = 3'd1;
    localparam t_mode MODE_SDIV = 3'd2;
    localparam t_mode MODE_UMOD = 3'd3;
    localparam t_mode MODE_SMOD = 3'd4;

    // Which word the output stage returns.
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_QUO  = 2'd0;
    localparam t_sel SEL_REM  = 2'd1;
    localparam t_sel SEL_ZERO = 2'd2;

    // Request state handed from cell to cell along the division chain.
    typedef struct packed {
        logic  is_div;  // cells perform a division step
        t_sel  sel;     // result selection at the output stage
        logic  neg_res; // negate the selected word
        logic  b_zero;  // divisor was zero
        t_word dvd;     // dividend bits, consumed from the top
        t_word dsr;     // divisor magnitude
        t_word rem;     // partial remainder
        t_word quo;     // quotient bits, or the product for multiply
    } t_div_data;

endpackage

FILE: rtl/core/mdm_prep.sv
// Front stage: decodes the mode, forms magnitudes and the product.
module mdm_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mdm_pkg::t_mode    i_mode,
    input  mdm_pkg::t_word    i_operand_a,
    input  mdm_pkg::t_word    i_operand_b,
    output logic              o_valid,
    input  logic              i_ready,
    output mdm_pkg::t_div_data o_data
);
    import mdm_pkg::*;

    logic      r_valid;
    t_div_data r_data;
    t_div_data n_data;
    logic      w_na;
    logic      w_nb;
    t_word     w_ma;
    t_word     w_mb;
    t_word     w_prod;

    // Operand signs and wrapped magnitudes.
    assign w_na   = i_operand_a[DATA_WIDTH-1];
    assign w_nb   = i_operand_b[DATA_WIDTH-1];
    assign w_ma   = w_na ? (~i_operand_a + t_word'(1)) : i_operand_a;
    assign w_mb   = w_nb ? (~i_operand_b + t_word'(1)) : i_operand_b;
    assign w_prod = i_operand_a * i_operand_b;

    // Set up the request for the division chain.
    always_comb begin
        n_data         = '0;
        n_data.b_zero  = (i_operand_b == '0);
        unique case (i_mode)
            MODE_MUL: begin
                n_data.sel = SEL_QUO;
                n_data.quo = w_prod;
            end
            MODE_UDIV: begin
                n_data.is_div = 1'b1;
                n_data.sel    = SEL_QUO;
                n_data.dvd    = i_operand_a;
                n_data.dsr    = i_operand_b;
            end
            MODE_SDIV: begin
                n_data.is_div  = 1'b1;
                n_data.sel     = SEL_QUO;
                n_data.neg_res = w_na ^ w_nb;
                n_data.dvd     = w_ma;
                n_data.dsr     = w_mb;
            end
            MODE_UMOD: begin
                n_data.is_div = 1'b1;
                n_data.sel    = SEL_REM;
                n_data.dvd    = i_operand_a;
                n_data.dsr    = i_operand_b;
            end
            MODE_SMOD: begin
                n_data.is_div  = 1'b1;
                n_data.sel     = SEL_REM;
                n_data.neg_res = w_na;
                n_data.dvd     = w_ma;
                n_data.dsr     = w_mb;
            end
            default: begin
                n_data.sel = SEL_ZERO;
            end
        endcase
    end

    // Stage register with its own ready.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/mdm_div_cell.sv
// One restoring division step with its stage register.
module mdm_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mdm_pkg::t_div_data i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output mdm_pkg::t_div_data o_data
);
    import mdm_pkg::*;

    logic      r_valid;
    t_div_data r_data;
    t_div_data n_data;
    t_word     w_shift;
    logic      w_carry;
    logic      w_take;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    assign w_carry = i_data.rem[DATA_WIDTH-1];
    assign w_shift = {i_data.rem[DATA_WIDTH-2:0], i_data.dvd[DATA_WIDTH-1]};
    assign w_take  = w_carry || (w_shift >= i_data.dsr);

    always_comb begin
        n_data = i_data;
        if (i_data.is_div) begin
            n_data.rem = w_take ? (w_shift - i_data.dsr) : w_shift;
            n_data.quo = {i_data.quo[DATA_WIDTH-2:0], w_take};
            n_data.dvd = {i_data.dvd[DATA_WIDTH-2:0], 1'b0};
        end
    end

    // Stage register; it moves whenever it is empty or its neighbor takes it.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/mdm_post.sv
// Output stage: selects quotient, remainder or product and applies the sign.
module mdm_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mdm_pkg::t_div_data i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output mdm_pkg::t_word     o_result_word
);
    import mdm_pkg::*;

    logic  r_valid;
    t_word r_word;
    t_word w_pick;
    t_word n_word;

    // Pick the word; a remainder by zero is zero.
    always_comb begin
        unique case (i_data.sel)
            SEL_QUO:  w_pick = i_data.quo;
            SEL_REM:  w_pick = i_data.b_zero ? '0 : i_data.rem;
            default:  w_pick = '0;
        endcase
        n_word = i_data.neg_res ? (~w_pick + t_word'(1)) : w_pick;
    end

    // Output register.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid       = r_valid;
    assign o_result_word = r_word;

endmodule

FILE: rtl/core/int32_mul_div_mod_unit.sv
// Top level of the 32-bit multiply, divide and modulo unit.
// Requests enter on i_valid/o_ready with i_mode, i_operand_a and i_operand_b;
// a request is taken at a clock edge where both are high. Each request gives
// one result on o_valid/i_ready carrying o_result_word.
// Mode 0 returns the low product word, modes 1 and 2 the unsigned and signed
// quotient, modes 3 and 4 the unsigned and signed remainder, other modes zero.
// The datapath is a front stage, a chain of 32 restoring division cells (one
// quotient bit each) and an output register; every request passes all of
// them in order, multiplies included. Throughput is one request per cycle
// while the receiver keeps up; the chain holds up to 34 requests.
// Each stage has its own valid bit and moves when empty or when the next
// stage moves, so a stalled receiver halts only the filled tail of the
// chain and new requests keep entering while bubbles remain.
// Results leave in request order. Reset (i_rst_n low at a clock edge) drops
// every request in flight and empties the chain.
module int32_mul_div_mod_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mdm_pkg::t_mode i_mode,
    input  mdm_pkg::t_word i_operand_a,
    input  mdm_pkg::t_word i_operand_b,
    output logic           o_valid,
    input  logic           i_ready,
    output mdm_pkg::t_word o_result_word
);
    import mdm_pkg::*;

    // Links between neighboring stages: link 0 leaves the front stage,
    // link k+1 leaves division cell k.
    logic      w_valid [DATA_WIDTH+1];
    logic      w_ready [DATA_WIDTH+1];
    t_div_data w_data  [DATA_WIDTH+1];

    mdm_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (w_valid[0]),
        .i_ready     (w_ready[0]),
        .o_data      (w_data[0])
    );

    // One cell per quotient bit.
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
        mdm_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    mdm_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_valid[DATA_WIDTH]),
        .o_ready       (w_ready[DATA_WIDTH]),
        .i_data        (w_data[DATA_WIDTH]),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_word (o_result_word)
    );

endmodule
